// ----- rtl/core/fci_pkg.sv -----
`default_nettype none

package fci_pkg;

    // fixed geometry
    localparam int ADDR_BITS       = 20;
    localparam int DATA_BITS       = 16;
    localparam int DEF_ARRAY_WORDS = 1048576;
    localparam int DEF_BLOCK_COUNT = 32;
    localparam int BLOCK_SHIFT     = 15;
    localparam int BLOCK_WORDS     = 1 << BLOCK_SHIFT;
    localparam int PAGE_BITS       = 7;
    localparam int PAGE_WORDS      = 1 << PAGE_BITS;
    localparam int QUEUE_DEPTH     = 2;
    localparam int CFG_IDX_BITS    = 1;

    // command bytes
    localparam logic [7:0] CMD_READ_ZERO  = 8'h00;
    localparam logic [7:0] CMD_READ_ARRAY = 8'hFF;
    localparam logic [7:0] CMD_IDENT      = 8'h90;
    localparam logic [7:0] CMD_EXT_STATUS = 8'h71;
    localparam logic [7:0] CMD_CLEAR      = 8'h50;
    localparam logic [7:0] CMD_ABORT      = 8'h80;
    localparam logic [7:0] CMD_PAGE_LOAD  = 8'hE0;
    localparam logic [7:0] CMD_PAGE_PROG  = 8'h0C;
    localparam logic [7:0] CMD_ERASE      = 8'h20;
    localparam logic [7:0] CMD_UNLOCK     = 8'h97;
    localparam logic [7:0] CMD_LOCK       = 8'h77;
    localparam logic [7:0] CMD_CONFIRM    = 8'hD0;

    // result status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_BADADDR = 3'd1;
    localparam logic [2:0] ST_UNSUP   = 3'd2;
    localparam logic [2:0] ST_PROT    = 3'd3;
    localparam logic [2:0] ST_NOCONF  = 3'd4;
    localparam logic [2:0] ST_BADREG  = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAKER  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DEVICE = 1'b1;

    localparam logic [15:0] ERASED_WORD   = 16'hFFFF;
    localparam logic [15:0] MAKER_RESET   = 16'h0089;
    localparam logic [15:0] DEVICE_RESET  = 16'h66A0;
    localparam logic [7:0]  GLOBAL_STATUS = 8'h86;
    localparam logic [7:0]  BLOCK_ST_BASE = 8'h80;

    typedef struct packed {
        logic                 cmd;
        logic [ADDR_BITS-1:0] addr;
        logic [DATA_BITS-1:0] wdata;
    } t_item;

    typedef struct packed {
        logic [DATA_BITS-1:0] rdata;
        logic [2:0]           status;
    } t_result;

    typedef enum logic [2:0] {
        OP_RESP,
        OP_READ,
        OP_PAGE,
        OP_ERASE,
        OP_PROG
    } t_op_kind;

    typedef struct packed {
        t_op_kind             kind;
        logic [ADDR_BITS-1:0] addr;
        logic [DATA_BITS-1:0] data;
        logic [7:0]           count;
        logic [2:0]           status;
    } t_op;

    typedef struct packed {
        logic init_busy;
    } t_back_stat;

endpackage

`default_nettype wire

// ----- rtl/core/fci_front.sv -----
`default_nettype none

module fci_front #(
    parameter int ARRAY_WORDS = fci_pkg::DEF_ARRAY_WORDS,
    parameter int BLOCK_COUNT = fci_pkg::DEF_BLOCK_COUNT
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_accept,
    input  wire fci_pkg::t_item                      i_item,
    input  wire logic                                i_cfg_we,
    input  wire logic [fci_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  wire logic [fci_pkg::DATA_BITS-1:0]       i_cfg_wdata,
    output fci_pkg::t_op                             o_op,
    output logic                                     o_push
);
    import fci_pkg::*;

    localparam int BI_W = $clog2(BLOCK_COUNT);
    localparam int BN_W = ADDR_BITS - BLOCK_SHIFT;
    localparam int NMAP = 1 << BN_W;
    localparam logic [ADDR_BITS:0] ARRAY_LIM = (ADDR_BITS+1)'(ARRAY_WORDS);

    logic [7:0]             r_mode, n_mode;
    logic [1:0]             r_phase, n_phase;
    logic [7:0]             r_words, n_words;
    logic [BLOCK_COUNT-1:0] r_wp, n_wp;
    logic [15:0]            r_maker, r_device;

    logic [BI_W-1:0] blk_map [NMAP];
    logic [BI_W-1:0] blk;
    logic [7:0]      v8;
    logic            conf, in_range, known, restart;
    logic [1:0]      eff_phase;
    logic [7:0]      eff_mode;
    logic [BLOCK_SHIFT-1:0] off;

    // block number wraps modulo the block count
    always_comb begin
        for (int j = 0; j < NMAP; j++) begin
            blk_map[j] = BI_W'(j % BLOCK_COUNT);
        end
    end

    assign blk      = blk_map[i_item.addr[ADDR_BITS-1:BLOCK_SHIFT]];
    assign off      = i_item.addr[BLOCK_SHIFT-1:0];
    assign v8       = i_item.wdata[7:0];
    assign conf     = (v8 == CMD_CONFIRM);
    assign in_range = ({1'b0, i_item.addr} < ARRAY_LIM);

    always_comb begin
        case (r_mode)
            CMD_READ_ZERO, CMD_READ_ARRAY, CMD_EXT_STATUS, CMD_ABORT, CMD_CLEAR,
            CMD_IDENT, CMD_PAGE_LOAD, CMD_UNLOCK, CMD_LOCK, CMD_ERASE,
            CMD_PAGE_PROG: known = 1'b1;
            default:       known = 1'b0;
        endcase
    end

    // a pending identifier or unknown command restarts as a new command
    assign restart   = (r_phase != 2'd0) && ((r_mode == CMD_IDENT) || !known);
    assign eff_phase = restart ? 2'd0 : r_phase;
    assign eff_mode  = (eff_phase == 2'd0) ? v8 : r_mode;

    always_comb begin
        n_mode       = r_mode;
        n_phase      = r_phase;
        n_words      = r_words;
        n_wp         = r_wp;
        o_op.kind    = OP_RESP;
        o_op.addr    = i_item.addr;
        o_op.data    = '0;
        o_op.count   = r_words;
        o_op.status  = ST_OK;
        if (i_accept) begin
            if (!in_range) begin
                o_op.status = ST_BADADDR;
            end else if (!i_item.cmd) begin
                n_phase = 2'd0;
                case (r_mode)
                    CMD_READ_ZERO: ;
                    CMD_READ_ARRAY: o_op.kind = OP_READ;
                    CMD_IDENT: begin
                        if (i_item.addr == ADDR_BITS'(0)) begin
                            o_op.data = r_maker;
                        end else if (i_item.addr == ADDR_BITS'(1)) begin
                            o_op.data = r_device;
                        end else if (i_item.addr != ADDR_BITS'(2)) begin
                            o_op.status = ST_BADREG;
                        end
                    end
                    CMD_EXT_STATUS: begin
                        if (off == BLOCK_SHIFT'(1)) begin
                            o_op.data = {8'h00, BLOCK_ST_BASE | {1'b0, r_wp[blk], 6'b0}};
                        end else if (off == BLOCK_SHIFT'(2)) begin
                            o_op.data = {8'h00, GLOBAL_STATUS};
                        end else begin
                            o_op.status = ST_BADREG;
                        end
                    end
                    default: o_op.status = ST_UNSUP;
                endcase
            end else begin
                n_mode = eff_mode;
                case (eff_mode)
                    CMD_READ_ZERO, CMD_READ_ARRAY, CMD_EXT_STATUS: n_phase = 2'd0;
                    CMD_ABORT, CMD_CLEAR: begin
                        n_phase = 2'd0;
                        n_mode  = CMD_READ_ARRAY;
                    end
                    CMD_IDENT: n_phase = 2'd1;
                    CMD_PAGE_LOAD: begin
                        case (eff_phase)
                            2'd0: n_phase = 2'd1;
                            2'd1: begin
                                n_words = v8;
                                n_phase = 2'd2;
                            end
                            2'd2: n_phase = 2'd3;
                            default: begin
                                o_op.kind = OP_PAGE;
                                o_op.data = i_item.wdata;
                                if (r_words == 8'd0) begin
                                    n_phase = 2'd0;
                                end else begin
                                    n_words = r_words - 8'd1;
                                end
                            end
                        endcase
                    end
                    CMD_UNLOCK, CMD_LOCK: begin
                        if (eff_phase == 2'd0) begin
                            n_phase = 2'd1;
                        end else begin
                            n_phase = 2'd0;
                            if (!conf) begin
                                o_op.status = ST_NOCONF;
                            end else begin
                                n_wp[blk] = (eff_mode == CMD_UNLOCK);
                            end
                        end
                    end
                    CMD_ERASE: begin
                        if (eff_phase == 2'd0) begin
                            n_phase = 2'd1;
                        end else begin
                            n_phase = 2'd0;
                            if (!conf) begin
                                o_op.status = ST_NOCONF;
                            end else if (!r_wp[blk]) begin
                                o_op.status = ST_PROT;
                            end else begin
                                o_op.kind = OP_ERASE;
                            end
                        end
                    end
                    CMD_PAGE_PROG: begin
                        if (eff_phase == 2'd0) begin
                            n_phase = 2'd1;
                        end else if (eff_phase == 2'd1) begin
                            n_words = v8;
                            n_phase = 2'd2;
                        end else begin
                            n_phase = 2'd0;
                            if (r_wp[blk]) begin
                                o_op.kind = OP_PROG;
                            end else begin
                                o_op.status = ST_PROT;
                            end
                        end
                    end
                    default: begin
                        n_phase     = 2'd0;
                        o_op.status = ST_UNSUP;
                    end
                endcase
            end
        end
    end

    assign o_push = i_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= CMD_READ_ARRAY;
            r_phase  <= 2'd0;
            r_words  <= 8'd0;
            r_wp     <= '0;
            r_maker  <= MAKER_RESET;
            r_device <= DEVICE_RESET;
        end else begin
            r_mode  <= n_mode;
            r_phase <= n_phase;
            r_words <= n_words;
            r_wp    <= n_wp;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MAKER:  r_maker  <= i_cfg_wdata;
                    CFG_DEVICE: r_device <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/fci_fifo.sv -----
`default_nettype none

module fci_fifo (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire fci_pkg::t_op i_op,
    input  wire logic         i_pop,
    output fci_pkg::t_op      o_head,
    output logic              o_empty,
    output logic              o_full
);
    import fci_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_op              r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_level;
    logic [PTR_W-1:0] wr_ptr;

    assign wr_ptr  = r_rd_ptr + r_level[PTR_W-1:0];
    assign o_head  = r_slot[r_rd_ptr];
    assign o_empty = (r_level == '0);
    assign o_full  = (r_level == (PTR_W+1)'(QUEUE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_level <= r_level + (PTR_W+1)'(1);
                2'b01:   r_level <= r_level - (PTR_W+1)'(1);
                default: ;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("queue underflow");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/fci_back.sv -----
`default_nettype none

module fci_back #(
    parameter int ARRAY_WORDS = fci_pkg::DEF_ARRAY_WORDS
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire fci_pkg::t_op  i_op,
    output logic               o_pop,
    output fci_pkg::t_back_stat o_stat,
    output logic               o_done,
    output fci_pkg::t_result   o_result
);
    import fci_pkg::*;

    localparam int ADDR_W = $clog2(ARRAY_WORDS);
    localparam int SUM_W  = ADDR_BITS + 1;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_ERASE,
        S_P_RD,
        S_P_WR
    } t_state;

    t_state               r_state;
    logic [ADDR_W-1:0]    r_cnt;
    logic [ADDR_BITS-1:0] r_addr;
    logic [7:0]           r_len;
    logic                 r_done;
    t_result              r_result;

    logic [15:0] r_array [ARRAY_WORDS];
    logic [15:0] r_page  [PAGE_WORDS];
    logic [15:0] r_mem_q, r_page_q;

    logic [SUM_W-1:0]     sum;
    logic                 in_arr;
    logic                 mem_we, pg_we;
    logic [ADDR_W-1:0]    mem_wa, mem_ra;
    logic [15:0]          mem_wd;
    logic [PAGE_BITS-1:0] pg_wa, pg_ra;

    assign sum    = {1'b0, r_addr} + SUM_W'(r_cnt);
    assign in_arr = (sum < SUM_W'(ARRAY_WORDS));

    always_comb begin
        o_pop  = 1'b0;
        mem_we = 1'b0;
        mem_wa = sum[ADDR_W-1:0];
        mem_wd = ERASED_WORD;
        mem_ra = i_op.addr[ADDR_W-1:0];
        pg_we  = 1'b0;
        pg_wa  = i_op.addr[PAGE_BITS-1:0];
        pg_ra  = sum[PAGE_BITS-1:0];
        case (r_state)
            S_INIT: begin
                mem_we = 1'b1;
                mem_wa = r_cnt;
            end
            S_IDLE: begin
                o_pop = i_valid;
                pg_we = i_valid && (i_op.kind == OP_PAGE);
            end
            S_ERASE: mem_we = in_arr;
            S_P_WR: begin
                mem_we = in_arr;
                mem_wd = r_page_q;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_array[mem_wa] <= mem_wd;
        end
        r_mem_q <= r_array[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (pg_we) begin
            r_page[pg_wa] <= i_op.data;
        end
        r_page_q <= r_page[pg_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_INIT: begin
                    r_cnt <= r_cnt + ADDR_W'(1);
                    if (r_cnt == ADDR_W'(ARRAY_WORDS - 1)) begin
                        r_cnt   <= '0;
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_cnt <= '0;
                        case (i_op.kind)
                            OP_READ:  r_state <= S_READ;
                            OP_ERASE: begin
                                r_addr  <= {i_op.addr[ADDR_BITS-1:BLOCK_SHIFT],
                                            BLOCK_SHIFT'(0)};
                                r_state <= S_ERASE;
                            end
                            OP_PROG: begin
                                r_addr  <= i_op.addr;
                                r_len   <= i_op.count;
                                r_state <= S_P_RD;
                            end
                            OP_PAGE: begin
                                r_done   <= 1'b1;
                                r_result <= '{rdata: '0, status: ST_OK};
                            end
                            default: begin
                                r_done   <= 1'b1;
                                r_result <= '{rdata: i_op.data, status: i_op.status};
                            end
                        endcase
                    end
                end
                S_READ: begin
                    r_done   <= 1'b1;
                    r_result <= '{rdata: r_mem_q, status: ST_OK};
                    r_state  <= S_IDLE;
                end
                S_ERASE: begin
                    r_cnt <= r_cnt + ADDR_W'(1);
                    if (r_cnt[BLOCK_SHIFT-1:0] == '1) begin
                        r_done   <= 1'b1;
                        r_result <= '{rdata: '0, status: ST_OK};
                        r_state  <= S_IDLE;
                    end
                end
                S_P_RD: r_state <= S_P_WR;
                S_P_WR: begin
                    if (r_cnt[7:0] == r_len) begin
                        r_done   <= 1'b1;
                        r_result <= '{rdata: '0, status: ST_OK};
                        r_state  <= S_IDLE;
                    end else begin
                        r_cnt   <= r_cnt + ADDR_W'(1);
                        r_state <= S_P_RD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done           = r_done;
    assign o_result         = r_result;
    assign o_stat.init_busy = (r_state == S_INIT);

`ifndef NO_ASSERTIONS
    a_quiet_in_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INIT) |=> !r_done)
        else $error("result during clearing pass");
    a_prog_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_P_WR && r_cnt[7:0] == r_len) |=> (r_done && r_state == S_IDLE))
        else $error("program did not finish");
    a_erase_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ERASE) |-> (r_addr[BLOCK_SHIFT-1:0] == '0))
        else $error("erase base not block aligned");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/flash_command_interface_core.sv -----
// Channel   | Handshake              | Payload        | Notes
// ----------+------------------------+----------------+-----------------------------
// command   | start / busy           | i_item         | transfer when start && !busy
// result    | o_done (1-cycle strobe)| o_result       | receiver cannot stall
// config    | i_cfg_we               | i_cfg_idx/wdata| write only, no wait
//
// Order: an accepted transfer is queued; status-only accesses and page loads
// answer from a registered result, array reads after a registered read, erase
// after a write per block word, program after a page read and write per word.
// Reset: synchronous, active low; a clearing pass over all ARRAY_WORDS words fills
// the array with ones, busy stays high meanwhile. Config writes work throughout.
// Stalls: busy rises when the 2-entry queue between decode and execute is full.
`default_nettype none

module flash_command_interface_core #(
    parameter int ARRAY_WORDS = fci_pkg::DEF_ARRAY_WORDS,
    parameter int BLOCK_COUNT = fci_pkg::DEF_BLOCK_COUNT
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire fci_pkg::t_item                    i_item,
    output logic                                   o_done,
    output fci_pkg::t_result                       o_result,
    input  wire logic                              i_cfg_we,
    input  wire logic [fci_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  wire logic [fci_pkg::DATA_BITS-1:0]     i_cfg_wdata
);
    import fci_pkg::*;

    logic       accept, push, pop, q_empty, q_full;
    t_op        op_in, op_head;
    t_back_stat back_stat;

    // front decodes, queue decouples, back touches the memories
    assign busy   = back_stat.init_busy || q_full;
    assign accept = start && !busy;

    fci_front #(
        .ARRAY_WORDS(ARRAY_WORDS),
        .BLOCK_COUNT(BLOCK_COUNT)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata),
        .o_op       (op_in),
        .o_push     (push)
    );

    fci_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_op   (op_in),
        .i_pop  (pop),
        .o_head (op_head),
        .o_empty(q_empty),
        .o_full (q_full)
    );

    fci_back #(
        .ARRAY_WORDS(ARRAY_WORDS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (!q_empty),
        .i_op    (op_head),
        .o_pop   (pop),
        .o_stat  (back_stat),
        .o_done  (o_done),
        .o_result(o_result)
    );

endmodule

`default_nettype wire
